/* src/eps_pkg.sv */
// Shared constants, widths and state type for the edge pool sampler.
// Depends on nothing; eps_mod, the top level and the testbench use it, eps_ram does not.
package eps_pkg;

  localparam int MAX_NODES  = 64;
  localparam int POOL_DEPTH = MAX_NODES * (MAX_NODES - 1);
  localparam int NODE_W     = 6;
  localparam int NCFG_W     = 7;
  localparam int SLOT_W     = $clog2(POOL_DEPTH);
  localparam int CNT_W      = 13;
  localparam int PAIR_W     = 2 * NODE_W;
  localparam int RAND_W     = 31;
  localparam int STEP_W     = $clog2(RAND_W);
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 2;
  localparam int REM_W      = 12;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [MODE_W-1:0] MODE_FILL   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd2;

  localparam logic [STAT_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_ABSENT = 2'd2;

  localparam logic [NCFG_W-1:0] NODES_RESET = NCFG_W'(MAX_NODES);
  localparam logic [NCFG_W-1:0] NODES_MIN   = 7'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FILL,
    S_RM_IDX,
    S_RM_SLOT,
    S_RM_CHK,
    S_DIV,
    S_DR_RD,
    S_DR_GET,
    S_SW_LAST,
    S_SW_MAP
  } state_e;

endpackage

/* src/eps_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module eps_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4032
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/eps_mod.sv */
// Bit-serial restoring modulo unit: one quotient bit per cycle.
// Depends on eps_pkg for the operand widths.
module eps_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [eps_pkg::RAND_W-1:0]  dividend_i,
  input  logic [eps_pkg::CNT_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [eps_pkg::SLOT_W-1:0]  rem_o
);
  import eps_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [RAND_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W:0]    trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[RAND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(RAND_W - 1);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[SLOT_W-1:0];

endmodule

/* src/edge_pool_sampler_top.sv */
// Top level of the edge pool sampler: control FSM, APB register and the pool and map RAMs.
// Depends on eps_pkg, eps_ram and eps_mod.
//
// Channel   Direction  Handshake             Payload
// command   in         start & !busy         mode_i, src_node_i, dst_node_i, random_value_i
// result    out        done_o, one cycle     edge_src_o, edge_dst_o, status_o, remaining_o
// config    in         APB, pready always 1  node_count at byte address 0
//
// Fill walks every ordered pair below the clamped node count, writing a pool RAM entry and
// its map entry for each pair of distinct nodes. Remove reads the map RAM for the pair's slot,
// then the pool RAM at that slot; a hit swap-removes the edge, a miss returns absent.
// Draw runs the bit-serial modulo unit, reads the pool RAM at the remainder and swap-removes.
// A rejected beat returns its result in the next cycle. The result beat is shown for one
// cycle and cannot be stalled; busy is high while a beat is in work. Reset leaves the RAMs
// unwritten and the pool empty.
module edge_pool_sampler_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [eps_pkg::MODE_W-1:0]   mode_i,
  input  logic [eps_pkg::NODE_W-1:0]   src_node_i,
  input  logic [eps_pkg::NODE_W-1:0]   dst_node_i,
  input  logic [eps_pkg::RAND_W-1:0]   random_value_i,
  output logic                         done_o,
  output logic [eps_pkg::NODE_W-1:0]   edge_src_o,
  output logic [eps_pkg::NODE_W-1:0]   edge_dst_o,
  output logic [eps_pkg::STAT_W-1:0]   status_o,
  output logic [eps_pkg::REM_W-1:0]    remaining_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [eps_pkg::APB_AW-1:0]   paddr,
  input  logic [eps_pkg::APB_DW-1:0]   pwdata,
  output logic [eps_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import eps_pkg::*;

  function automatic logic [CNT_W-1:0] pair_index(input logic [NCFG_W-1:0] n,
                                                  input logic [NODE_W-1:0] i,
                                                  input logic [NODE_W-1:0] j);
    logic [CNT_W-1:0] p;
    p = CNT_W'(n - NCFG_W'(1)) * CNT_W'(i) + CNT_W'(j) - CNT_W'(j > i);
    return p;
  endfunction

  function automatic logic [NCFG_W-1:0] clamp_nodes(input logic [NCFG_W-1:0] n);
    logic [NCFG_W-1:0] c;
    c = n;
    if (n < NODES_MIN) begin
      c = NODES_MIN;
    end else if (n > NODES_RESET) begin
      c = NODES_RESET;
    end
    return c;
  endfunction

  state_e state_q, state_d;

  logic [NCFG_W-1:0] node_count_q, node_count_d;
  logic [NCFG_W-1:0] fill_nodes_q, fill_nodes_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [NODE_W-1:0] s_q, s_d, d_q, d_d;
  logic [NODE_W-1:0] i_q, i_d, j_q, j_d;
  logic [SLOT_W-1:0] k_q, k_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W-1:0] m_q, m_d;
  logic [PAIR_W-1:0] f_q, f_d;

  logic              done_q, done_d;
  logic [NODE_W-1:0] es_q, es_d, ed_q, ed_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [REM_W-1:0]  remaining_q, remaining_d;

  logic              accept, cfg_wr, rm_ok, fill_last, rm_hit;
  logic [CNT_W-1:0]  count_m1, m_in, m_back;

  logic              pool_we, map_we;
  logic [SLOT_W-1:0] pool_waddr, pool_raddr, map_waddr, map_raddr;
  logic [PAIR_W-1:0] pool_wdata, pool_rdata;
  logic [SLOT_W-1:0] map_wdata, map_rdata;

  logic              mod_start, mod_done;
  logic [SLOT_W-1:0] mod_rem;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign count_m1  = count_q - CNT_W'(1);
  assign m_in      = pair_index(fill_nodes_q, src_node_i, dst_node_i);
  assign m_back    = pair_index(fill_nodes_q, f_q[PAIR_W-1:NODE_W], f_q[NODE_W-1:0]);
  assign rm_ok     = ({1'b0, src_node_i} < fill_nodes_q) && ({1'b0, dst_node_i} < fill_nodes_q)
                     && (src_node_i != dst_node_i) && (count_q != '0);
  assign fill_last = ({1'b0, i_q} == fill_nodes_q - NCFG_W'(1))
                     && ({1'b0, j_q} == fill_nodes_q - NCFG_W'(1));
  assign rm_hit    = ({1'b0, slot_q} < count_q) && (pool_rdata == {s_q, d_q});
  assign mod_start = accept && (mode_i == MODE_DRAW) && (count_q != '0);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? APB_DW'(node_count_q) : '0;

  always_comb begin
    node_count_d = node_count_q;
    if (cfg_wr && (paddr[2] == 1'b0)) begin
      node_count_d = pwdata[NCFG_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_i)
            MODE_FILL:   state_d = S_FILL;
            MODE_REMOVE: state_d = rm_ok ? S_RM_IDX : S_IDLE;
            MODE_DRAW:   state_d = (count_q != '0) ? S_DIV : S_IDLE;
            default:     state_d = S_IDLE;
          endcase
        end
      end
      S_FILL:    state_d = fill_last ? S_IDLE : S_FILL;
      S_RM_IDX:  state_d = S_RM_SLOT;
      S_RM_SLOT: state_d = S_RM_CHK;
      S_RM_CHK:  state_d = rm_hit ? S_SW_LAST : S_IDLE;
      S_DIV:     state_d = mod_done ? S_DR_RD : S_DIV;
      S_DR_RD:   state_d = S_DR_GET;
      S_DR_GET:  state_d = S_SW_LAST;
      S_SW_LAST: state_d = S_SW_MAP;
      S_SW_MAP:  state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fill_nodes_d = fill_nodes_q;
    count_d      = count_q;
    s_d          = s_q;
    d_d          = d_q;
    i_d          = i_q;
    j_d          = j_q;
    k_d          = k_q;
    slot_d       = slot_q;
    m_d          = m_q;
    f_d          = f_q;
    done_d       = 1'b0;
    es_d         = es_q;
    ed_d         = ed_q;
    status_d     = status_q;
    remaining_d  = remaining_q;
    pool_we      = 1'b0;
    pool_waddr   = slot_q;
    pool_wdata   = pool_rdata;
    pool_raddr   = '0;
    map_we       = 1'b0;
    map_waddr    = k_q;
    map_wdata    = k_q;
    map_raddr    = m_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          s_d         = src_node_i;
          d_d         = dst_node_i;
          m_d         = m_in[SLOT_W-1:0];
          es_d        = '0;
          ed_d        = '0;
          remaining_d = count_q[REM_W-1:0];
          case (mode_i)
            MODE_FILL: begin
              fill_nodes_d = clamp_nodes(node_count_q);
              i_d          = '0;
              j_d          = '0;
              k_d          = '0;
            end
            MODE_REMOVE: begin
              if (!rm_ok) begin
                done_d   = 1'b1;
                status_d = STATUS_ABSENT;
              end
            end
            MODE_DRAW: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = STATUS_EMPTY;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = STATUS_ABSENT;
            end
          endcase
        end
      end
      S_FILL: begin
        if (i_q != j_q) begin
          pool_we    = 1'b1;
          pool_waddr = k_q;
          pool_wdata = {i_q, j_q};
          map_we     = 1'b1;
          k_d        = k_q + SLOT_W'(1);
        end
        if ({1'b0, j_q} == fill_nodes_q - NCFG_W'(1)) begin
          j_d = '0;
          i_d = i_q + NODE_W'(1);
        end else begin
          j_d = j_q + NODE_W'(1);
        end
        if (fill_last) begin
          count_d     = CNT_W'(k_q);
          done_d      = 1'b1;
          status_d    = STATUS_OK;
          es_d        = '0;
          ed_d        = '0;
          remaining_d = k_q;
        end
      end
      S_RM_SLOT: begin
        slot_d     = map_rdata;
        pool_raddr = map_rdata;
      end
      S_RM_CHK: begin
        if (rm_hit) begin
          count_d    = count_m1;
          pool_raddr = count_m1[SLOT_W-1:0];
        end else begin
          done_d      = 1'b1;
          status_d    = STATUS_ABSENT;
          es_d        = '0;
          ed_d        = '0;
          remaining_d = count_q[REM_W-1:0];
        end
      end
      S_DR_RD: begin
        slot_d     = mod_rem;
        pool_raddr = mod_rem;
      end
      S_DR_GET: begin
        s_d        = pool_rdata[PAIR_W-1:NODE_W];
        d_d        = pool_rdata[NODE_W-1:0];
        count_d    = count_m1;
        pool_raddr = count_m1[SLOT_W-1:0];
      end
      S_SW_LAST: begin
        pool_we    = 1'b1;
        pool_waddr = slot_q;
        pool_wdata = pool_rdata;
        f_d        = pool_rdata;
      end
      S_SW_MAP: begin
        if (m_back < CNT_W'(POOL_DEPTH)) begin
          map_we    = 1'b1;
          map_waddr = m_back[SLOT_W-1:0];
          map_wdata = slot_q;
        end
        done_d      = 1'b1;
        status_d    = STATUS_OK;
        es_d        = s_q;
        ed_d        = d_q;
        remaining_d = count_q[REM_W-1:0];
      end
      default: begin
        pool_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= NODES_RESET;
      fill_nodes_q <= NODES_MIN;
      count_q      <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      fill_nodes_q <= fill_nodes_d;
      count_q      <= count_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q         <= s_d;
    d_q         <= d_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    slot_q      <= slot_d;
    m_q         <= m_d;
    f_q         <= f_d;
    es_q        <= es_d;
    ed_q        <= ed_d;
    status_q    <= status_d;
    remaining_q <= remaining_d;
  end

  eps_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (POOL_DEPTH)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rdata)
  );

  eps_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (POOL_DEPTH)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  eps_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (random_value_i),
    .divisor_i  (count_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign done_o      = done_q;
  assign edge_src_o  = es_q;
  assign edge_dst_o  = ed_q;
  assign status_o    = status_q;
  assign remaining_o = remaining_q;

endmodule

/* dv/edge_pool_sampler_top_test.sv */
// Self-checking testbench for edge_pool_sampler_top: directed table, then random fill/remove/draw
// phases checked against an in-bench model of the pool and its reverse map.
// Depends on eps_pkg and the edge_pool_sampler_top RTL.
module edge_pool_sampler_top_test;
  import eps_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;
  localparam logic [APB_AW-1:0] REG_NODE_COUNT = 3'd0;
  localparam int                OPS_TARGET     = 550;
  localparam int                DRAIN_CYCLES   = 60;
  localparam longint            TIMEOUT_TU     = 64'd80_000_000;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [RAND_W-1:0] rnd;
  } op_t;

  typedef struct packed {
    logic [NODE_W-1:0] edge_src;
    logic [NODE_W-1:0] edge_dst;
    logic [STAT_W-1:0] status;
    logic [REM_W-1:0]  remaining;
  } outcome_t;

  typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [NCFG_W-1:0] nodes;
    op_t               op;
    bit                typed;
    outcome_t          want;
  } dir_row_t;

  localparam outcome_t UNTYPED = '0;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   mode_i;
  logic [NODE_W-1:0]   src_node_i;
  logic [NODE_W-1:0]   dst_node_i;
  logic [RAND_W-1:0]   random_value_i;
  logic                done_o;
  logic [NODE_W-1:0]   edge_src_o;
  logic [NODE_W-1:0]   edge_dst_o;
  logic [STAT_W-1:0]   status_o;
  logic [REM_W-1:0]    remaining_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  logic [NODE_W-1:0]   pool_src [POOL_DEPTH];
  logic [NODE_W-1:0]   pool_dst [POOL_DEPTH];
  int unsigned         slot_map [POOL_DEPTH];
  int unsigned         pool_cnt = 0;
  int unsigned         fill_n = 2;
  logic [NCFG_W-1:0]   cfg_nodes = NODES_RESET;

  outcome_t            outcome_q [$];
  int                  mismatch_cnt = 0;
  int                  ops_sent = 0;

  dir_row_t dir_rows [0:29] = '{
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd0, 6'd1, 31'd0}, 1'b1, '{6'd0, 6'd0, STATUS_ABSENT, 12'd0}},
    '{ROW_CMD, 7'd0, '{MODE_DRAW, 6'd0, 6'd0, 31'h7fffffff}, 1'b1,
      '{6'd0, 6'd0, STATUS_EMPTY, 12'd0}},
    '{ROW_CMD, 7'd0, '{MODE_UNUSED, 6'd63, 6'd63, 31'h7fffffff}, 1'b1,
      '{6'd0, 6'd0, STATUS_ABSENT, 12'd0}},
    '{ROW_CMD, 7'd0, '{MODE_FILL, 6'd0, 6'd0, 31'd0}, 1'b1, '{6'd0, 6'd0, STATUS_OK, 12'd4032}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd0, 6'd1, 31'd0}, 1'b1, '{6'd0, 6'd1, STATUS_OK, 12'd4031}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd0, 6'd1, 31'd0}, 1'b1,
      '{6'd0, 6'd0, STATUS_ABSENT, 12'd4031}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd5, 6'd5, 31'd0}, 1'b1,
      '{6'd0, 6'd0, STATUS_ABSENT, 12'd4031}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd63, 6'd62, 31'd0}, 1'b1,
      '{6'd63, 6'd62, STATUS_OK, 12'd4030}},
    '{ROW_CMD, 7'd0, '{MODE_DRAW, 6'd0, 6'd0, 31'd0}, 1'b0, UNTYPED},
    '{ROW_CMD, 7'd0, '{MODE_DRAW, 6'd0, 6'd0, 31'h7fffffff}, 1'b0, UNTYPED},
    '{ROW_CMD, 7'd0, '{MODE_UNUSED, 6'd0, 6'd0, 31'd0}, 1'b1,
      '{6'd0, 6'd0, STATUS_ABSENT, 12'd4028}},
    '{ROW_CFG, 7'd0, '0, 1'b0, UNTYPED},
    '{ROW_CMD, 7'd0, '{MODE_FILL, 6'd0, 6'd0, 31'd0}, 1'b1, '{6'd0, 6'd0, STATUS_OK, 12'd2}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd2, 6'd0, 31'd0}, 1'b1,
      '{6'd0, 6'd0, STATUS_ABSENT, 12'd2}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd1, 6'd0, 31'd0}, 1'b1, '{6'd1, 6'd0, STATUS_OK, 12'd1}},
    '{ROW_CMD, 7'd0, '{MODE_DRAW, 6'd0, 6'd0, 31'h55555555}, 1'b1,
      '{6'd0, 6'd1, STATUS_OK, 12'd0}},
    '{ROW_CMD, 7'd0, '{MODE_DRAW, 6'd0, 6'd0, 31'd0}, 1'b1, '{6'd0, 6'd0, STATUS_EMPTY, 12'd0}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd0, 6'd1, 31'd0}, 1'b1,
      '{6'd0, 6'd0, STATUS_ABSENT, 12'd0}},
    '{ROW_CFG, 7'd127, '0, 1'b0, UNTYPED},
    '{ROW_CMD, 7'd0, '{MODE_FILL, 6'd0, 6'd0, 31'd0}, 1'b1, '{6'd0, 6'd0, STATUS_OK, 12'd4032}},
    '{ROW_CFG, 7'd1, '0, 1'b0, UNTYPED},
    '{ROW_CMD, 7'd0, '{MODE_FILL, 6'd0, 6'd0, 31'd0}, 1'b1, '{6'd0, 6'd0, STATUS_OK, 12'd2}},
    '{ROW_CFG, 7'd65, '0, 1'b0, UNTYPED},
    '{ROW_CMD, 7'd0, '{MODE_FILL, 6'd0, 6'd0, 31'd0}, 1'b1, '{6'd0, 6'd0, STATUS_OK, 12'd4032}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd63, 6'd0, 31'd0}, 1'b1,
      '{6'd63, 6'd0, STATUS_OK, 12'd4031}},
    '{ROW_CFG, 7'd3, '0, 1'b0, UNTYPED},
    '{ROW_CMD, 7'd0, '{MODE_FILL, 6'd0, 6'd0, 31'd0}, 1'b1, '{6'd0, 6'd0, STATUS_OK, 12'd6}},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd2, 6'd3, 31'd0}, 1'b1,
      '{6'd0, 6'd0, STATUS_ABSENT, 12'd6}},
    '{ROW_CMD, 7'd0, '{MODE_DRAW, 6'd0, 6'd0, 31'd5}, 1'b0, UNTYPED},
    '{ROW_CMD, 7'd0, '{MODE_REMOVE, 6'd0, 6'd63, 31'd0}, 1'b1,
      '{6'd0, 6'd0, STATUS_ABSENT, 12'd5}}
  };

  edge_pool_sampler_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .src_node_i     (src_node_i),
    .dst_node_i     (dst_node_i),
    .random_value_i (random_value_i),
    .done_o         (done_o),
    .edge_src_o     (edge_src_o),
    .edge_dst_o     (edge_dst_o),
    .status_o       (status_o),
    .remaining_o    (remaining_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  function automatic void note_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int unsigned pair_slot_index(int unsigned n, int unsigned i, int unsigned j);
    return (n - 1) * i + j - ((j > i) ? 1 : 0);
  endfunction

  // The last live entry moves into the hole and its map entry follows it.
  function automatic void swap_out_slot(int unsigned slot);
    int unsigned m;
    pool_cnt--;
    pool_src[slot] = pool_src[pool_cnt];
    pool_dst[slot] = pool_dst[pool_cnt];
    m = pair_slot_index(fill_n, pool_src[slot], pool_dst[slot]);
    if (m < POOL_DEPTH) begin
      slot_map[m] = slot;
    end
  endfunction

  function automatic outcome_t apply_pool_op(op_t op);
    outcome_t    res;
    int unsigned n;
    int unsigned k;
    int unsigned slot;
    res = '{edge_src: '0, edge_dst: '0, status: STATUS_ABSENT, remaining: '0};
    case (op.mode)
      MODE_FILL: begin
        n = (cfg_nodes < NODES_MIN) ? NODES_MIN : (cfg_nodes > MAX_NODES) ? MAX_NODES : cfg_nodes;
        fill_n = n;
        k = 0;
        for (int unsigned i = 0; i < n; i++) begin
          for (int unsigned j = 0; j < n; j++) begin
            if (j != i) begin
              pool_src[k] = NODE_W'(i);
              pool_dst[k] = NODE_W'(j);
              slot_map[k] = k;
              k++;
            end
          end
        end
        pool_cnt = k;
        res.status = STATUS_OK;
      end
      MODE_REMOVE: begin
        if (op.src < fill_n && op.dst < fill_n && op.src != op.dst && pool_cnt > 0) begin
          slot = slot_map[pair_slot_index(fill_n, op.src, op.dst)];
          if (slot < pool_cnt && pool_src[slot] == op.src && pool_dst[slot] == op.dst) begin
            swap_out_slot(slot);
            res.edge_src = op.src;
            res.edge_dst = op.dst;
            res.status   = STATUS_OK;
          end
        end
      end
      MODE_DRAW: begin
        if (pool_cnt == 0) begin
          res.status = STATUS_EMPTY;
        end else begin
          slot = op.rnd % pool_cnt;
          res.edge_src = pool_src[slot];
          res.edge_dst = pool_dst[slot];
          swap_out_slot(slot);
          res.status = STATUS_OK;
        end
      end
      default: begin
      end
    endcase
    res.remaining = REM_W'(pool_cnt);
    return res;
  endfunction

  task automatic issue_op(input op_t op, input int unsigned gap, input bit typed,
                          input outcome_t want);
    outcome_t predicted;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start          <= 1'b1;
    mode_i         <= op.mode;
    src_node_i     <= op.src;
    dst_node_i     <= op.dst;
    random_value_i <= op.rnd;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predicted = apply_pool_op(op);
    outcome_q.push_back(typed ? want : predicted);
    if (op.mode != MODE_UNUSED) begin
      ops_sent++;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_DW-1:0] wdata,
                          output logic [APB_DW-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_NODE_COUNT;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_node_count(input logic [NCFG_W-1:0] nodes);
    logic [APB_DW-1:0] rd;
    wait_idle();
    apb_xfer(1'b1, {(APB_DW - NCFG_W)'($urandom()), nodes}, rd);
    cfg_nodes = nodes;
    apb_xfer(1'b0, '0, rd);
    if (rd !== APB_DW'(nodes)) begin
      note_mismatch($sformatf("mismatch: node_count readback expected %0d actual %0d", nodes, rd));
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && done_o) begin
      if (outcome_q.size() == 0) begin
        note_mismatch("mismatch: result beat with nothing expected");
      end else begin
        want = outcome_q.pop_front();
        if (edge_src_o !== want.edge_src || edge_dst_o !== want.edge_dst ||
            status_o !== want.status || remaining_o !== want.remaining) begin
          note_mismatch($sformatf(
            "mismatch: expected src %0d dst %0d status %0d rem %0d, got %0d %0d %0d %0d",
            want.edge_src, want.edge_dst, want.status, want.remaining,
            edge_src_o, edge_dst_o, status_o, remaining_o));
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_TU);
    $display("status: fail");
    $finish;
  end

  initial begin
    op_t               op;
    bit                burst;
    int unsigned       pick;
    int unsigned       phase_len;
    int unsigned       slot;
    logic [NCFG_W-1:0] nodes;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    start          = 1'b0;
    mode_i         = '0;
    src_node_i     = '0;
    dst_node_i     = '0;
    random_value_i = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        set_node_count(dir_rows[r].nodes);
      end else begin
        issue_op(dir_rows[r].op, $urandom_range(0, 12), dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Each phase refills the pool under a new node count and then works it down.
    while (ops_sent < OPS_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        nodes = $urandom_range(0, 1) ? NCFG_W'($urandom_range(0, 1))
                                     : NCFG_W'($urandom_range(65, 127));
      end else if (pick == 1) begin
        nodes = NCFG_W'(MAX_NODES);
      end else if (pick <= 4) begin
        nodes = NCFG_W'($urandom_range(11, 63));
      end else begin
        nodes = NCFG_W'($urandom_range(2, 10));
      end
      set_node_count(nodes);
      burst = ($urandom_range(0, 2) == 0);
      op = '{mode: MODE_FILL, src: NODE_W'($urandom()), dst: NODE_W'($urandom()),
             rnd: RAND_W'($urandom())};
      issue_op(op, burst ? 0 : $urandom_range(0, 12), 1'b0, UNTYPED);
      phase_len = $urandom_range(6, 40);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        op = '{mode: MODE_REMOVE, src: NODE_W'($urandom()), dst: NODE_W'($urandom()),
               rnd: RAND_W'($urandom())};
        if (pick < 40) begin
          if (pool_cnt > 0) begin
            slot   = $urandom_range(0, pool_cnt - 1);
            op.src = pool_src[slot];
            op.dst = pool_dst[slot];
          end else begin
            op.src = NODE_W'($urandom_range(0, fill_n - 1));
            op.dst = NODE_W'($urandom_range(0, fill_n - 1));
          end
        end else if (pick < 70) begin
          op.mode = MODE_DRAW;
        end else if (pick < 80) begin
        end else if (pick < 88) begin
          op.dst = op.src;
        end else if (pick < 93) begin
          op.src = NODE_W'($urandom_range(0, fill_n - 1));
          op.dst = NODE_W'($urandom_range(0, fill_n - 1));
        end else if (pick < 97) begin
          op.mode = MODE_UNUSED;
        end else begin
          op.mode = MODE_FILL;
        end
        issue_op(op, burst ? 0 : $urandom_range(0, 12), 1'b0, UNTYPED);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && outcome_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
